@@ rtl/jddm_pkg.sv @@
// ----------------------------------------------------------------------------
// jddm_pkg
// Types and constants shared by the joystick demand mapper and its checker.
// ----------------------------------------------------------------------------
package jddm_pkg;

    localparam int SAMPLE_W = 10;
    localparam int MARGIN_W = 8;
    localparam int DEMAND_W = 12;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_NOMINAL_NEUTRAL = 3'd0,
        CFG_NEUTRAL_MARGIN  = 3'd1,
        CFG_NEUTRAL_DEMAND  = 3'd2,
        CFG_DEMAND_MAX      = 3'd3,
        CFG_DEMAND_MIN      = 3'd4
    } cfg_index_t;

    localparam logic [SAMPLE_W-1:0] RST_NOMINAL_NEUTRAL = 10'd514;
    localparam logic [MARGIN_W-1:0] RST_NEUTRAL_MARGIN  = 8'd16;
    localparam logic [DEMAND_W-1:0] RST_NEUTRAL_DEMAND  = 12'd1115;
    localparam logic [DEMAND_W-1:0] RST_DEMAND_MAX      = 12'd1700;
    localparam logic [DEMAND_W-1:0] RST_DEMAND_MIN      = 12'd520;

    typedef struct packed {
        logic [SAMPLE_W-1:0] speed_sample;
        logic [SAMPLE_W-1:0] direction_sample;
    } sample_pair_t;

    typedef struct packed {
        logic [DEMAND_W-1:0] speed_demand;
        logic [DEMAND_W-1:0] direction_demand;
        logic                calibrated;
    } demand_pair_t;

endpackage

@@ rtl/joystick_deadband_demand_mapper.sv @@
// ----------------------------------------------------------------------------
// joystick_deadband_demand_mapper
// Latches joystick neutral positions, then maps each sample pair to DAC
// demand codes through a deadband, a 21/8 gain and min/max clamps.
// ----------------------------------------------------------------------------
//  channel  | ports                           | beat
//  ---------+---------------------------------+---------------------------
//  input    | s_valid s_ready s_data          | speed and direction sample
//  result   | m_valid m_ready m_data          | two demand codes, cal flag
//  config   | cfg_we cfg_addr cfg_wdata       | one register write
//
//  two register stages: input register, then result register
//  one beat per cycle while the result is not stalled
//  the mapping and calibration latch sit between the two stages
//  aresetn clears valids, calibration and config registers to defaults
//  a stalled result holds the pipe; s_ready follows back through both stages
// ----------------------------------------------------------------------------
module joystick_deadband_demand_mapper
    import jddm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sample_pair_t          s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output demand_pair_t          m_data,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [SAMPLE_W-1:0] nominal_neutral_reg;
    logic [MARGIN_W-1:0] neutral_margin_reg;
    logic [DEMAND_W-1:0] neutral_demand_reg;
    logic [DEMAND_W-1:0] demand_max_reg;
    logic [DEMAND_W-1:0] demand_min_reg;

    logic                in_valid_reg;
    sample_pair_t        in_data_reg;
    logic                out_valid_reg;
    demand_pair_t        out_data_reg;
    demand_pair_t        out_data_next;

    logic                is_cal_reg, is_cal_next;
    logic [SAMPLE_W-1:0] speed_neutral_reg, speed_neutral_next;
    logic [SAMPLE_W-1:0] dir_neutral_reg, dir_neutral_next;

    logic                advance;
    logic                cal_hit;

    function automatic logic in_window(
        input logic [SAMPLE_W-1:0] x,
        input logic [SAMPLE_W-1:0] c,
        input logic [MARGIN_W-1:0] m
    );
        logic [SAMPLE_W:0] x_ext;
        logic [SAMPLE_W:0] c_ext;
        logic [SAMPLE_W:0] m_ext;
        x_ext = {1'b0, x};
        c_ext = {1'b0, c};
        m_ext = {3'b000, m};
        return ((x_ext + m_ext) > c_ext) && (x_ext < (c_ext + m_ext));
    endfunction

    function automatic logic [DEMAND_W-1:0] map_axis(
        input logic [SAMPLE_W-1:0] x,
        input logic [SAMPLE_W-1:0] n,
        input logic [MARGIN_W-1:0] m,
        input logic [DEMAND_W-1:0] base,
        input logic [DEMAND_W-1:0] hi,
        input logic [DEMAND_W-1:0] lo
    );
        logic [SAMPLE_W:0]        x_ext;
        logic [SAMPLE_W:0]        n_ext;
        logic [SAMPLE_W:0]        m_ext;
        logic signed [SAMPLE_W:0] dev;
        logic signed [15:0]       dev_ext;
        logic signed [15:0]       dev21;
        logic signed [16:0]       sum;
        logic signed [16:0]       sum_adj;
        logic signed [13:0]       q;
        logic signed [13:0]       hi_s;
        logic signed [13:0]       lo_s;
        x_ext   = {1'b0, x};
        n_ext   = {1'b0, n};
        m_ext   = {3'b000, m};
        dev     = $signed(x_ext - n_ext);
        dev_ext = {{5{dev[SAMPLE_W]}}, dev};
        if ((x_ext > (n_ext + m_ext)) || ((x_ext + m_ext) < n_ext)) begin
            dev21 = (dev_ext <<< 4) + (dev_ext <<< 2) + dev_ext;
        end else begin
            dev21 = 16'sd0;
        end
        sum     = $signed({2'b00, base, 3'b000}) + $signed({dev21[15], dev21});
        // truncate toward zero
        sum_adj = sum + (sum[16] ? 17'sd7 : 17'sd0);
        q       = $signed(sum_adj[16:3]);
        hi_s    = $signed({2'b00, hi});
        lo_s    = $signed({2'b00, lo});
        if (q > hi_s) begin
            q = hi_s;
        end
        if (q < lo_s) begin
            q = lo_s;
        end
        return q[DEMAND_W-1:0];
    endfunction

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign cal_hit = in_window(in_data_reg.speed_sample, nominal_neutral_reg,
                               neutral_margin_reg)
                  && in_window(in_data_reg.direction_sample, nominal_neutral_reg,
                               neutral_margin_reg);

    always_comb begin
        is_cal_next        = is_cal_reg;
        speed_neutral_next = speed_neutral_reg;
        dir_neutral_next   = dir_neutral_reg;
        if (!is_cal_reg) begin
            if (cal_hit) begin
                is_cal_next        = 1'b1;
                speed_neutral_next = in_data_reg.speed_sample;
                dir_neutral_next   = in_data_reg.direction_sample;
            end
            out_data_next.speed_demand     = neutral_demand_reg;
            out_data_next.direction_demand = neutral_demand_reg;
            out_data_next.calibrated       = cal_hit;
        end else begin
            out_data_next.speed_demand = map_axis(in_data_reg.speed_sample,
                speed_neutral_reg, neutral_margin_reg, neutral_demand_reg,
                demand_max_reg, demand_min_reg);
            out_data_next.direction_demand = map_axis(in_data_reg.direction_sample,
                dir_neutral_reg, neutral_margin_reg, neutral_demand_reg,
                demand_max_reg, demand_min_reg);
            out_data_next.calibrated = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nominal_neutral_reg <= RST_NOMINAL_NEUTRAL;
            neutral_margin_reg  <= RST_NEUTRAL_MARGIN;
            neutral_demand_reg  <= RST_NEUTRAL_DEMAND;
            demand_max_reg      <= RST_DEMAND_MAX;
            demand_min_reg      <= RST_DEMAND_MIN;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_addr))
                CFG_NOMINAL_NEUTRAL: nominal_neutral_reg <= cfg_wdata[SAMPLE_W-1:0];
                CFG_NEUTRAL_MARGIN:  neutral_margin_reg  <= cfg_wdata[MARGIN_W-1:0];
                CFG_NEUTRAL_DEMAND:  neutral_demand_reg  <= cfg_wdata[DEMAND_W-1:0];
                CFG_DEMAND_MAX:      demand_max_reg      <= cfg_wdata[DEMAND_W-1:0];
                CFG_DEMAND_MIN:      demand_min_reg      <= cfg_wdata[DEMAND_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            is_cal_reg        <= 1'b0;
            speed_neutral_reg <= '0;
            dir_neutral_reg   <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg     <= 1'b1;
                is_cal_reg        <= is_cal_next;
                speed_neutral_reg <= speed_neutral_next;
                dir_neutral_reg   <= dir_neutral_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ rtl/jddm_checker.sv @@
// ----------------------------------------------------------------------------
// jddm_checker
// Port-level assertions for the joystick demand mapper, bound to its top.
// ----------------------------------------------------------------------------
module jddm_checker
    import jddm_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input demand_pair_t          m_data
);

    logic cal_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_seen_reg <= 1'b0;
        end else if (m_valid && m_ready && m_data.calibrated) begin
            cal_seen_reg <= 1'b1;
        end
    end

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // result held while stalled
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // calibration never drops once reported
    a_cal_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && cal_seen_reg |-> m_data.calibrated)
        else $error("calibrated flag dropped");

    // uncalibrated results carry the same demand on both axes
    a_uncal_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.calibrated |->
            m_data.speed_demand == m_data.direction_demand)
        else $error("uncalibrated demands differ");

endmodule

bind joystick_deadband_demand_mapper jddm_checker u_jddm_checker (.*);
